// ===== hdl/rhm_pkg.sv =====
// Shared constants and types of the region history matcher.
package rhm_pkg;

    localparam int HISTORY_LEN = 4;
    localparam int TABLE_DEPTH = 256;

    localparam int ID_W     = 32;
    localparam int HASH_W   = 64;
    localparam int REGION_W = 32;
    localparam int DET_W    = 32;

    localparam logic [HASH_W-1:0] HASH_GOLDEN = 64'h0000_0000_9e37_79b9;
    localparam int HASH_SHL = 6;
    localparam int HASH_SHR = 2;

    localparam int CNT_W   = $clog2(HISTORY_LEN + 1);
    localparam int HIST_IW = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int TBL_AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W  = $clog2(TABLE_DEPTH + 1);

    localparam int S_DATA_W  = 32;
    localparam int S_USER_W  = 1;
    localparam int M_FIELD_W = HASH_W + REGION_W + 1 + DET_W + 1;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // Outcome of one table lookup.
    typedef struct packed {
        logic                full;
        logic [REGION_W-1:0] rep;
    } tbl_res_t;

endpackage

// ===== hdl/rhm_hist_fold.sv =====
// Class ID history and the iterative hash fold over it.
module rhm_hist_fold (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [rhm_pkg::ID_W-1:0]   id,
    output logic [rhm_pkg::HASH_W-1:0] hash,
    output logic                       done
);
    import rhm_pkg::*;

    logic [ID_W-1:0]   hist_reg [HISTORY_LEN];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  k_reg;
    logic              busy_reg;
    logic [HASH_W-1:0] h_reg, h_step;
    logic              hist_full;

    assign hist_full  = (count_reg == CNT_W'(HISTORY_LEN));
    assign count_next = hist_full ? count_reg : count_reg + CNT_W'(1);

    // One fold step, shared across all history entries.
    assign h_step = h_reg ^ (HASH_W'(hist_reg[k_reg[HIST_IW-1:0]]) + HASH_GOLDEN
                    + (h_reg << HASH_SHL) + (h_reg >> HASH_SHR));

    assign hash = h_reg;
    assign done = busy_reg && (k_reg == count_reg);

    always_ff @(posedge aclk) begin
        if (push) begin
            if (hist_full) begin
                for (int k = 1; k < HISTORY_LEN; k++) begin
                    hist_reg[k-1] <= hist_reg[k];
                end
                hist_reg[HISTORY_LEN-1] <= id;
            end else begin
                hist_reg[count_reg[HIST_IW-1:0]] <= id;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            k_reg     <= '0;
        end else if (push) begin
            count_reg <= count_next;
            busy_reg  <= 1'b1;
            k_reg     <= '0;
        end else if (busy_reg) begin
            if (k_reg < count_reg) begin
                k_reg <= k_reg + CNT_W'(1);
            end else begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            h_reg <= HASH_W'(count_next);
        end else if (busy_reg && (k_reg < count_reg)) begin
            h_reg <= h_step;
        end
    end

endmodule

// ===== hdl/rhm_table.sv =====
// Hash table with a linear search, one entry compared per cycle.
module rhm_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [rhm_pkg::HASH_W-1:0]   hash,
    input  logic [rhm_pkg::REGION_W-1:0] region,
    output logic                         done,
    output rhm_pkg::tbl_res_t            res
);
    import rhm_pkg::*;

    typedef enum logic [1:0] {
        TS_IDLE   = 2'b01,
        TS_SEARCH = 2'b10
    } tbl_state_t;

    logic [HASH_W-1:0]   mem_hash   [TABLE_DEPTH];
    logic [REGION_W-1:0] mem_region [TABLE_DEPTH];

    tbl_state_t          state_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   addr_reg;
    logic                cmp_vld_reg;
    logic [HASH_W-1:0]   rd_hash_reg;
    logic [REGION_W-1:0] rd_region_reg;
    logic [HASH_W-1:0]   key_reg;
    logic [REGION_W-1:0] region_reg;
    logic                done_reg;
    tbl_res_t            res_reg;

    logic issue, hit, miss, has_room, wr_en;

    assign issue    = (state_reg == TS_SEARCH) && (addr_reg < fill_reg);
    assign hit      = (state_reg == TS_SEARCH) && cmp_vld_reg && (rd_hash_reg == key_reg);
    assign miss     = (state_reg == TS_SEARCH) && !cmp_vld_reg && !issue;
    assign has_room = (fill_reg < FILL_W'(TABLE_DEPTH));
    assign wr_en    = miss && has_room;

    assign done = done_reg;
    assign res  = res_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_hash[fill_reg[TBL_AW-1:0]]   <= key_reg;
            mem_region[fill_reg[TBL_AW-1:0]] <= region_reg;
        end
        rd_hash_reg   <= mem_hash[addr_reg[TBL_AW-1:0]];
        rd_region_reg <= mem_region[addr_reg[TBL_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= TS_IDLE;
            fill_reg    <= '0;
            addr_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                TS_IDLE: begin
                    if (start) begin
                        state_reg   <= TS_SEARCH;
                        addr_reg    <= '0;
                        cmp_vld_reg <= 1'b0;
                    end
                end
                TS_SEARCH: begin
                    cmp_vld_reg <= issue;
                    if (issue) begin
                        addr_reg <= addr_reg + FILL_W'(1);
                    end
                    if (hit || miss) begin
                        state_reg <= TS_IDLE;
                        done_reg  <= 1'b1;
                    end
                    if (wr_en) begin
                        fill_reg <= fill_reg + FILL_W'(1);
                    end
                end
                default: begin
                    state_reg <= TS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (start && (state_reg == TS_IDLE)) begin
            key_reg    <= hash;
            region_reg <= region;
        end
        if (hit) begin
            res_reg.full <= 1'b0;
            res_reg.rep  <= rd_region_reg;
        end else if (miss) begin
            res_reg.full <= !has_room;
            res_reg.rep  <= region_reg;
        end
    end

endmodule

// ===== hdl/region_history_matcher_top.sv =====
// Top level of the region history matcher: stream ports, sequencer and result register.
//
// Input words arrive on the s_ channel. s_tuser carries the region-start flag and
// s_tdata the 32-bit class ID. A word with the flag low marks a region end: it is
// taken and dropped without a result. A start word pushes its ID into the history,
// folds the history into a 64-bit hash and searches the hash table for it.
// One result word leaves on the m_ channel for every start word.
//
// The time from acceptance of a start word to m_tvalid grows with H, the history
// length in use (one hash step per cycle in the shared fold unit), and with F, the
// number of filled table entries (the table memory is read one entry per cycle).
// s_tready is high only while the block is idle, so words are handled one at a time.
//
// The result sits in an output register. If the receiver stalls, that word is held
// and the next input word may still be taken and processed; it then waits for the
// register to drain before it is written there.
// Reset (aresetn low, synchronous) empties the history and the table, clears the
// region number and the detailed count, and drops any result not yet taken.
module region_history_matcher_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input words.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rhm_pkg::S_DATA_W-1:0]   s_tdata,  // [31:0] class_region_id
    input  logic [rhm_pkg::S_USER_W-1:0]   s_tuser,  // [0] is_region_start
    // Result words.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [63:0] history_hash, [95:64] representative_region, [96] fast_forward,
    // [128:97] detailed_total, [129] table_full, [135:130] zero
    output logic [rhm_pkg::M_DATA_W-1:0]   m_tdata
);
    import rhm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FOLD   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_EMIT   = 4'b1000
    } top_state_t;

    top_state_t          state_reg;
    logic [REGION_W-1:0] region_reg;
    logic [DET_W-1:0]    det_reg, det_next;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic                in_acc, push;
    logic [HASH_W-1:0]   hash;
    logic                fold_done;
    logic                tbl_done;
    tbl_res_t            tbl_res;
    logic                fast, out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign push     = in_acc && s_tuser[0];

    rhm_hist_fold u_fold (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .id      (s_tdata[ID_W-1:0]),
        .hash    (hash),
        .done    (fold_done)
    );

    rhm_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_FOLD && fold_done),
        .hash    (hash),
        .region  (region_reg),
        .done    (tbl_done),
        .res     (tbl_res)
    );

    // A region that is its own representative runs detailed.
    assign fast     = (tbl_res.rep != region_reg);
    assign det_next = (!fast && (det_reg != '1)) ? det_reg + DET_W'(1) : det_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            region_reg   <= '0;
            det_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (push) begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    if (fold_done) begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (tbl_done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        det_reg      <= det_next;
                        region_reg   <= region_reg + REGION_W'(1);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload; it is only written when the output register is free.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_tdata_reg <= M_DATA_W'({tbl_res.full, det_next, fast, tbl_res.rep, hash});
        end
    end

endmodule

// ===== tb/region_history_matcher_checker.sv =====
// Checker for the region history matcher: predicts each result word and compares it.
module region_history_matcher_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [rhm_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [rhm_pkg::S_USER_W-1:0]   s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [rhm_pkg::M_DATA_W-1:0]   m_tdata,
    output int                             mismatches,
    output int                             waiting,
    output int                             results_seen,
    output int                             fast_seen,
    output int                             full_seen
);
    import rhm_pkg::*;

    localparam int REP_LSB  = HASH_W;
    localparam int FAST_BIT = HASH_W + REGION_W;
    localparam int DET_LSB  = FAST_BIT + 1;
    localparam int FULL_BIT = DET_LSB + DET_W;

    // The block holds at most one word in work and one in its output register.
    localparam int OUTCOME_DEPTH = 4;
    localparam int OUTCOME_AW    = 2;

    typedef struct {
        logic [HASH_W-1:0]   hash;
        logic [REGION_W-1:0] rep;
        logic                fast;
        logic [DET_W-1:0]    detailed;
        logic                full;
    } region_outcome_t;

    logic [ID_W-1:0]       recent_ids [HISTORY_LEN];
    int                    recent_len;
    logic [REGION_W-1:0]   region_no;
    logic [HASH_W-1:0]     seen_hash [TABLE_DEPTH];
    logic [REGION_W-1:0]   seen_region [TABLE_DEPTH];
    int                    seen_fill;
    logic [DET_W-1:0]      detailed_no;
    region_outcome_t       outcome_mem [OUTCOME_DEPTH];
    logic [OUTCOME_AW-1:0] rd_ptr;
    logic [OUTCOME_AW-1:0] wr_ptr;
    int                    pending;
    region_outcome_t       due;

    // Pushes the ID, folds the history and looks the hash up, updating the state.
    function automatic region_outcome_t predict_region(input logic [ID_W-1:0] id);
        region_outcome_t o;
        logic [HASH_W-1:0] h;
        logic hit;
        int k;
        if (recent_len == HISTORY_LEN) begin
            for (k = 1; k < HISTORY_LEN; k++)
                recent_ids[HIST_IW'(k-1)] = recent_ids[HIST_IW'(k)];
            recent_ids[HISTORY_LEN-1] = id;
        end else begin
            recent_ids[HIST_IW'(recent_len)] = id;
            recent_len++;
        end
        h = HASH_W'(recent_len);
        for (k = 0; k < recent_len; k++)
            h = h ^ ({{(HASH_W-ID_W){1'b0}}, recent_ids[HIST_IW'(k)]} + HASH_GOLDEN
                     + (h << HASH_SHL) + (h >> HASH_SHR));
        hit    = 1'b0;
        o.rep  = region_no;
        o.full = 1'b0;
        for (k = 0; k < seen_fill && !hit; k++) begin
            if (seen_hash[TBL_AW'(k)] == h) begin
                hit   = 1'b1;
                o.rep = seen_region[TBL_AW'(k)];
            end
        end
        if (!hit) begin
            if (seen_fill < TABLE_DEPTH) begin
                seen_hash[TBL_AW'(seen_fill)]   = h;
                seen_region[TBL_AW'(seen_fill)] = region_no;
                seen_fill++;
            end else begin
                o.full = 1'b1;
            end
        end
        o.fast = (o.rep != region_no);
        if (!o.fast && detailed_no != '1)
            detailed_no++;
        o.hash     = h;
        o.detailed = detailed_no;
        region_no++;
        return o;
    endfunction

    task automatic compare_field(input string name, input logic [HASH_W-1:0] want,
                                 input logic [HASH_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            recent_len   = 0;
            region_no    = '0;
            seen_fill    = 0;
            detailed_no  = '0;
            rd_ptr       = '0;
            wr_ptr       = '0;
            pending      = 0;
            mismatches   = 0;
            results_seen = 0;
            fast_seen    = 0;
            full_seen    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending == 0) begin
                    mismatches++;
                    $error("result word %h arrived with no start word waiting", m_tdata);
                end else begin
                    due = outcome_mem[rd_ptr];
                    rd_ptr++;
                    pending--;
                    if (due.fast) fast_seen++;
                    if (due.full) full_seen++;
                    compare_field("history_hash", due.hash, m_tdata[HASH_W-1:0]);
                    compare_field("representative_region", HASH_W'(due.rep),
                                  HASH_W'(m_tdata[REP_LSB +: REGION_W]));
                    compare_field("fast_forward", HASH_W'(due.fast),
                                  HASH_W'(m_tdata[FAST_BIT]));
                    compare_field("detailed_total", HASH_W'(due.detailed),
                                  HASH_W'(m_tdata[DET_LSB +: DET_W]));
                    compare_field("table_full", HASH_W'(due.full),
                                  HASH_W'(m_tdata[FULL_BIT]));
                end
            end
            if (s_tvalid && s_tready && s_tuser[0]) begin
                if (pending == OUTCOME_DEPTH) begin
                    mismatches++;
                    $error("more start words outstanding than the block can hold");
                end else begin
                    outcome_mem[wr_ptr] = predict_region(s_tdata[ID_W-1:0]);
                    wr_ptr++;
                    pending++;
                end
            end
        end
        waiting <= pending;
    end

endmodule

// ===== tb/region_history_matcher_top_test.sv =====
// Testbench top for the region history matcher: clock, reset, stimulus and verdict.
module region_history_matcher_top_test;
    import rhm_pkg::*;

    // The drain is longer than a start word with a full table takes to process, and
    // runs beyond the last expected result.
    localparam int DRAIN_CYCLES = 400;
    // The long receiver hold-off that lets the block fill up and stall its input.
    localparam int HOLD_CYCLES  = 700;
    localparam int PHASE_WORDS  = 340;
    localparam int PRESS_WORDS  = 20;
    localparam int END_PCT      = 12;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [S_USER_W-1:0]   s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    int mismatches, waiting, results_seen, fast_seen, full_seen;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int idle_pct = 0;
    int stall_pct = 0;
    // Handshake between the stimulus and the receiver for the long hold-off.
    logic pressure_on = 1'b0;
    logic pressure_over = 1'b0;

    int start_words = 0;
    int end_words = 0;

    // Class IDs reused so that histories repeat and hashes hit the table.
    logic [ID_W-1:0] id_pool [7];

    region_history_matcher_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    region_history_matcher_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .waiting      (waiting),
        .results_seen (results_seen),
        .fast_seen    (fast_seen),
        .full_seen    (full_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Safety net: a run that hangs ends here as a failure.
    initial begin
        #25_000_000;
        $display("region_history_matcher_top_test: errors");
        $finish;
    end

    // Receiver. It stalls at the rate of the current phase, and once, on request,
    // holds m_tready low for a long stretch that it counts itself.
    initial begin
        forever begin
            @(posedge aclk);
            if (pressure_on && !pressure_over) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                pressure_over = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one word after a random gap and returns at the edge where it is taken.
    // Only one assignment to s_tvalid happens per edge, so back-to-back words keep
    // the valid high without a glitch.
    task automatic send_word(input logic start, input logic [ID_W-1:0] id);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= start;
        s_tdata    <= id;
        do @(posedge aclk); while (!s_tready);
        if (start) start_words++;
        else end_words++;
    endtask

    // A region start, sometimes preceded by an end word that the block must ignore.
    task automatic send_region(input logic [ID_W-1:0] id);
        if ($urandom_range(99) < END_PCT)
            send_word(1'b0, $urandom);
        send_word(1'b1, id);
    endtask

    // Phase 0 and 2 draw from a pool of three IDs, phase 1 from another four, and the
    // last phase from all seven; a share of wholly random IDs is mixed in throughout.
    // The four-ID pool alone gives at most as many full-length histories as the table has entries.
    function automatic logic [ID_W-1:0] pick_id(input int phase);
        int wide_pct [4];
        wide_pct = '{5, 5, 40, 20};
        if ($urandom_range(99) < wide_pct[2'(phase)])
            return $urandom;
        unique case (phase)
            0, 2:    return id_pool[3'($urandom_range(2))];
            1:       return id_pool[3'(3 + $urandom_range(3))];
            default: return id_pool[3'($urandom_range(6))];
        endcase
    endfunction

    initial begin
        logic [ID_W-1:0] directed_ids [20];
        int idle_of [4];
        int stall_of [4];
        int phase;
        int n;

        idle_of  = '{0, 57, 0, 34};
        stall_of = '{0, 0, 57, 34};
        // Directed IDs: the field extremes, a history that grows through its first
        // lengths and then overflows, windows that repeat (so later starts hit the
        // table and fast-forward), alternating bit patterns and a run of one ID.
        directed_ids = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                         32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                         32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000,
                         32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h1234_5678,
                         32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678};
        foreach (id_pool[i]) id_pool[i] = $urandom;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // An end word before any start, and more of them inside the directed run.
        send_word(1'b0, 32'hFFFF_FFFF);
        for (n = 0; n < 20; n++) begin
            if (n == 3 || n == 11) send_word(1'b0, 32'h0000_0000);
            send_word(1'b1, directed_ids[5'(n)]);
        end

        for (phase = 0; phase < 4; phase++) begin
            idle_pct  = idle_of[2'(phase)];
            stall_pct = stall_of[2'(phase)];
            for (n = 0; n < PHASE_WORDS; n++)
                send_region(pick_id(phase));
            // After the unthrottled phase, keep offering words through the long
            // hold-off so that the held result stalls the input.
            if (phase == 0) begin
                idle_pct    = 0;
                stall_pct   = 0;
                pressure_on = 1'b1;
                for (n = 0; n < PRESS_WORDS; n++)
                    send_region(pick_id(0));
            end
        end
        s_tvalid <= 1'b0;
        stall_pct = 20;

        // Let the checker's count of outstanding words become current first.
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d start words and %0d end words; %0d results checked.",
                 start_words, end_words, results_seen);
        $display("Results covered %0d fast-forward decisions and %0d table-full cases.",
                 fast_seen, full_seen);
        if (mismatches == 0 && waiting == 0) begin
            $display("region_history_matcher_top_test: clean");
        end else begin
            $display("region_history_matcher_top_test: errors");
        end
        $finish;
    end

endmodule
